// ===== rtl/conv_tile_partition_search_unit_assert.svh =====
// Assertion macros for the convolution tile partition search unit
`ifndef CONV_TILE_PARTITION_SEARCH_UNIT_ASSERT_SVH
`define CONV_TILE_PARTITION_SEARCH_UNIT_ASSERT_SVH
// assert that a implies b on the next clock
`define CTPS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b on the same clock
`define CTPS_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/ctps_pkg.sv =====
// Types and constants for the convolution tile partition search unit
package ctps_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_AREA, ST_DIV_Q, ST_CIN, ST_ROWS, ST_COLS, ST_COST1, ST_COST2,
    ST_NEXT, ST_TIN, ST_TOUT, ST_BLOCKS, ST_LAST, ST_OSIZE, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_KERNEL = 2'd1,
    STATUS_NOFIT = 2'd2
  } status_t;

  localparam logic [31:0] COST_LIMIT = 32'h4000_0000;
  localparam int DIV_W = 34;
  localparam logic [8:0] SIZE9_MAX = 9'd511;
endpackage

// ===== rtl/conv_tile_partition_search_unit.sv =====
// Convolution tile partition search: one layer description in, one tiling result out
// Search: (P-k+1)^2 candidate tiles, P the padded side, k the kernel; each candidate that fits the
// degree takes four divisions on one shared divider, one that does not is skipped; the result is then
// derived from the best tile on the same divider (not when nothing fits); a kernel error skips the search.
// One transaction at a time: in_ready is low while one is in work or its result waits.
// Reset: synchronous active-high rst clears control state and sets poly_degree to 4096.
`include "conv_tile_partition_search_unit_assert.svh"
module conv_tile_partition_search_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  map_side,
  input  logic [3:0]  pad_amount,
  input  logic [4:0]  kernel_side,
  input  logic [12:0] channels_in,
  input  logic [12:0] channels_out,
  input  logic [3:0]  step_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [8:0]  tile_h,
  output logic [8:0]  tile_w,
  output logic [12:0] tile_in_channels,
  output logic [12:0] tile_out_channels,
  output logic [12:0] out_channel_blocks,
  output logic [12:0] in_channel_blocks,
  output logic [8:0]  row_blocks,
  output logic [8:0]  col_blocks,
  output logic [16:0] last_coeff_index,
  output logic [8:0]  out_size
);
  localparam int DW = ctps_pkg::DIV_W;

  ctps_pkg::state_t state, state_next;
  logic [16:0] poly_degree;
  logic [9:0]  p, kk, hh, ww, bh, bw;
  logic [12:0] cin, cout;
  logic [3:0]  stride;
  logic [9:0]  span;
  logic [18:0] area;
  logic [DW-1:0] tmp, cost;
  logic [31:0] best;
  logic        found;
  logic [12:0] tin, tout;
  logic [2:0]  phase;
  logic [12:0] tin_pick;

  // shared divider: quotient of num/den, restoring, one bit per cycle
  logic [DW-1:0] dnum, dden, dq, drem;
  logic [5:0]    dcnt;
  logic          dbusy, dstart, ddone;
  logic [DW-1:0] dstart_num, dstart_den;
  logic [DW-1:0] dtrial;

  assign dtrial = {drem[DW-2:0], dnum[DW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      if (dstart) begin
        dbusy <= 1'b1;
        dnum <= dstart_num;
        dden <= dstart_den;
        drem <= '0;
        dq <= '0;
        dcnt <= 6'(DW);
      end else if (dbusy) begin
        if (dtrial >= dden) begin
          drem <= dtrial - dden;
          dq <= {dq[DW-2:0], 1'b1};
        end else begin
          drem <= dtrial;
          dq <= {dq[DW-2:0], 1'b0};
        end
        dnum <= {dnum[DW-2:0], 1'b0};
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd1) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  // ceiling division helper: (a+b-1)/b, zero when b is zero
  function automatic logic [DW-1:0] cnum(input logic [DW-1:0] a, input logic [DW-1:0] b);
    cnum = (b == '0) ? '0 : a + b - 1'b1;
  endfunction
  function automatic logic [DW-1:0] cden(input logic [DW-1:0] b);
    cden = (b == '0) ? {{(DW-1){1'b0}}, 1'b1} : b;
  endfunction

  assign in_ready = (state == ctps_pkg::ST_IDLE) && !out_valid;
  assign tin_pick = (DW'(cin) < dq) ? cin : dq[12:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctps_pkg::ST_IDLE;
      poly_degree <= 17'd4096;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) poly_degree <= cfg_wdata;
      if (state == ctps_pkg::ST_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    dstart = 1'b0;
    dstart_num = '0;
    dstart_den = {{(DW-1){1'b0}}, 1'b1};
    case (state)
      ctps_pkg::ST_IDLE: if (in_valid && in_ready) state_next = ctps_pkg::ST_CHECK;
      ctps_pkg::ST_CHECK: begin
        if (kk == 10'd0 || kk > p) state_next = ctps_pkg::ST_OUT;
        else state_next = ctps_pkg::ST_AREA;
      end
      ctps_pkg::ST_AREA: begin
        if (area > {2'b00, poly_degree}) state_next = ctps_pkg::ST_NEXT;
        else begin
          dstart = 1'b1;
          dstart_num = DW'(poly_degree);
          dstart_den = DW'(area);
          state_next = ctps_pkg::ST_DIV_Q;
        end
      end
      ctps_pkg::ST_DIV_Q: if (ddone) begin
        dstart = 1'b1;
        dstart_num = cnum(DW'(cin), dq);
        dstart_den = cden(dq);
        state_next = ctps_pkg::ST_CIN;
      end
      ctps_pkg::ST_CIN: if (ddone) begin
        dstart = 1'b1;
        dstart_num = DW'(span) + DW'(hh - kk);
        dstart_den = DW'(hh - kk + 10'd1);
        state_next = ctps_pkg::ST_ROWS;
      end
      ctps_pkg::ST_ROWS: if (ddone) begin
        dstart = 1'b1;
        dstart_num = DW'(span) + DW'(ww - kk);
        dstart_den = DW'(ww - kk + 10'd1);
        state_next = ctps_pkg::ST_COLS;
      end
      ctps_pkg::ST_COLS: if (ddone) state_next = ctps_pkg::ST_COST1;
      ctps_pkg::ST_COST1: state_next = ctps_pkg::ST_COST2;
      ctps_pkg::ST_COST2: state_next = ctps_pkg::ST_NEXT;
      ctps_pkg::ST_NEXT: begin
        if (ww == p && hh == p) state_next = found ? ctps_pkg::ST_TIN : ctps_pkg::ST_OUT;
        else state_next = ctps_pkg::ST_AREA;
      end
      ctps_pkg::ST_TIN: begin
        if (phase == 3'd0) begin
          dstart = 1'b1;
          dstart_num = DW'(poly_degree);
          dstart_den = DW'(area);
        end else if (ddone) state_next = ctps_pkg::ST_TOUT;
      end
      ctps_pkg::ST_TOUT: begin
        if (phase == 3'd0) begin
          dstart = 1'b1;
          dstart_num = DW'(poly_degree);
          dstart_den = cden(tmp);
        end else if (ddone) state_next = ctps_pkg::ST_BLOCKS;
      end
      ctps_pkg::ST_BLOCKS: begin
        if (phase == 3'd0 || (phase != 3'd5 && ddone)) begin
          dstart = 1'b1;
          case (phase)
            3'd0: begin
              dstart_num = cnum(DW'(cout), DW'(tout));
              dstart_den = cden(DW'(tout));
            end
            3'd1: begin
              dstart_num = cnum(DW'(cin), DW'(tin));
              dstart_den = cden(DW'(tin));
            end
            3'd2: begin
              dstart_num = DW'(span) + DW'(bh - kk);
              dstart_den = DW'(bh - kk + 10'd1);
            end
            3'd3: begin
              dstart_num = DW'(span) + DW'(bw - kk);
              dstart_den = DW'(bw - kk + 10'd1);
            end
            default: begin
              dstart_num = DW'(p - kk) + DW'(stride);
              dstart_den = DW'(stride);
            end
          endcase
        end
        if (phase == 3'd5 && ddone) state_next = ctps_pkg::ST_LAST;
      end
      ctps_pkg::ST_LAST: state_next = ctps_pkg::ST_OSIZE;
      ctps_pkg::ST_OSIZE: state_next = ctps_pkg::ST_OUT;
      ctps_pkg::ST_OUT: state_next = ctps_pkg::ST_IDLE;
      default: state_next = ctps_pkg::ST_IDLE;
    endcase
  end

  logic [25:0] prod;
  logic [35:0] lastv;
  logic [35:0] lbase;
  assign prod = {13'd0, tout} * {13'd0, tin};
  assign lbase = 36'(20'(bw) * 20'(kk - 10'd1)) + 36'(kk) - 36'd1;

  always_ff @(posedge clk) begin
    case (state)
      ctps_pkg::ST_IDLE: if (in_valid && in_ready) begin
        p <= {1'b0, map_side} + {5'd0, pad_amount, 1'b0};
        kk <= {5'd0, kernel_side};
        cin <= channels_in;
        cout <= channels_out;
        stride <= (step_size == 4'd0) ? 4'd1 : step_size;
        found <= 1'b0;
        best <= ctps_pkg::COST_LIMIT;
        status <= ctps_pkg::STATUS_OK;
        tile_h <= '0; tile_w <= '0; tile_in_channels <= '0; tile_out_channels <= '0;
        out_channel_blocks <= '0; in_channel_blocks <= '0; row_blocks <= '0;
        col_blocks <= '0; last_coeff_index <= '0; out_size <= '0;
      end
      ctps_pkg::ST_CHECK: begin
        if (kk == 10'd0 || kk > p) status <= ctps_pkg::STATUS_KERNEL;
        span <= p - kk + 10'd1;
        hh <= kk;
        ww <= kk;
        area <= 19'(kk) * 19'(kk);
      end
      ctps_pkg::ST_CIN: if (ddone) tmp <= dq;
      ctps_pkg::ST_ROWS: if (ddone) cost <= DW'({10'd0, tmp[12:0]} * {13'd0, dq[9:0]});
      ctps_pkg::ST_COLS: if (ddone) tmp <= dq;
      ctps_pkg::ST_COST1: cost <= DW'({9'd0, cost[22:0]} * {22'd0, tmp[9:0]});
      ctps_pkg::ST_COST2: if (cost < DW'(best)) begin
        best <= cost[31:0];
        bh <= hh;
        bw <= ww;
        found <= 1'b1;
      end
      ctps_pkg::ST_NEXT: begin
        if (ww == p && hh == p) begin
          if (!found) status <= ctps_pkg::STATUS_NOFIT;
          else area <= 19'(bh) * 19'(bw);
        end else if (ww == p) begin
          ww <= kk;
          hh <= hh + 10'd1;
          area <= 19'(hh + 10'd1) * 19'(kk);
        end else begin
          ww <= ww + 10'd1;
          area <= 19'(hh) * 19'(ww + 10'd1);
        end
        phase <= 3'd0;
      end
      ctps_pkg::ST_TIN: begin
        if (phase == 3'd0) phase <= 3'd1;
        else if (ddone) begin
          tin <= tin_pick;
          tmp <= DW'({19'd0, tin_pick} * {13'd0, area});
          phase <= 3'd0;
        end
      end
      ctps_pkg::ST_TOUT: begin
        if (phase == 3'd0) phase <= 3'd1;
        else if (ddone) begin
          tout <= (tin == 13'd0) ? 13'd0 : ((DW'(cout) < dq) ? cout : dq[12:0]);
          phase <= 3'd0;
        end
      end
      ctps_pkg::ST_BLOCKS: begin
        if (phase == 3'd0) phase <= 3'd1;
        else if (ddone) begin
          case (phase)
            3'd1: out_channel_blocks <= dq[12:0];
            3'd2: in_channel_blocks <= dq[12:0];
            3'd3: row_blocks <= (dq > DW'(ctps_pkg::SIZE9_MAX)) ? ctps_pkg::SIZE9_MAX : dq[8:0];
            3'd4: col_blocks <= (dq > DW'(ctps_pkg::SIZE9_MAX)) ? ctps_pkg::SIZE9_MAX : dq[8:0];
            default: out_size <= (dq > DW'(ctps_pkg::SIZE9_MAX)) ? ctps_pkg::SIZE9_MAX : dq[8:0];
          endcase
          phase <= phase + 3'd1;
        end
      end
      ctps_pkg::ST_LAST: begin
        lastv <= 36'({17'd0, area[16:0]} * {17'd0, prod[16:0]});
      end
      ctps_pkg::ST_OSIZE: begin
        tile_h <= (bh > {1'b0, ctps_pkg::SIZE9_MAX}) ? ctps_pkg::SIZE9_MAX : bh[8:0];
        tile_w <= (bw > {1'b0, ctps_pkg::SIZE9_MAX}) ? ctps_pkg::SIZE9_MAX : bw[8:0];
        tile_in_channels <= tin;
        tile_out_channels <= tout;
        if (prod == 26'd0)
          last_coeff_index <= (lbase > 36'(area)) ? 17'(lbase - 36'(area)) : 17'd0;
        else last_coeff_index <= 17'(lastv - 36'(area) + lbase);
      end
      default: ;
    endcase
  end

  `CTPS_ASSERT_SAME(a_ready_idle, clk, rst, in_ready, state == ctps_pkg::ST_IDLE)
  `CTPS_ASSERT_NEXT(a_out_after, clk, rst, state == ctps_pkg::ST_OUT, out_valid)
  `CTPS_ASSERT_SAME(a_no_overlap, clk, rst, out_valid, !in_ready)
  `CTPS_ASSERT_SAME(a_zero_on_err, clk, rst, out_valid && status != ctps_pkg::STATUS_OK,
                    tile_h == 9'd0)
endmodule
